FILE: sv/sgma_pkg.sv
package sgma_pkg;

    // Fixed sizes of the filter.
    localparam int CHANNELS      = 4;
    localparam int WINDOW_LENGTH = 8;
    localparam int CH_W          = $clog2(CHANNELS);
    localparam int POS_W         = $clog2(WINDOW_LENGTH);
    localparam int SAMPLE_W      = 12;
    localparam int SUM_W         = SAMPLE_W + POS_W;
    localparam int COUNT_W       = 8;
    localparam int CFG_W         = 12;

    // Configuration register indexes and reset values.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_JUMP_THRESHOLD = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_CONFIRM_COUNT  = 1'b1;
    localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET    = 12'd64;
    localparam logic [COUNT_W-1:0]   CONFIRM_RESET      = 8'd3;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [CH_W-1:0]     t_channel;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [COUNT_W-1:0]  t_count;

    // Stored state of one channel, as seen by the decision logic.
    typedef struct packed {
        t_sample held;
        t_count  up_cnt;
        t_count  down_cnt;
        t_sum    sum;
        t_sample oldest;
    } t_chan_state;

    // Update of one channel produced for one item.
    typedef struct packed {
        logic    enter;
        t_count  up_cnt;
        t_count  down_cnt;
        t_sum    sum;
        t_sample held;
    } t_update;

endpackage

FILE: sv/sgma_gate.sv
module sgma_gate
    import sgma_pkg::*;
(
    input  t_sample     i_sample,
    input  t_chan_state i_state,
    input  t_sample     i_threshold,
    input  t_count      i_confirm,
    output t_update     o_upd
);

    logic [SAMPLE_W:0] high_limit;
    logic [SAMPLE_W:0] low_sum;
    logic              is_up;
    logic              above_floor;
    logic              is_down;
    t_count            up_bump;
    t_count            down_bump;
    t_sum              sum_new;

    // Widened compares so that held plus or minus threshold never wraps.
    assign high_limit  = {1'b0, i_state.held} + {1'b0, i_threshold};
    assign low_sum     = {1'b0, i_sample} + {1'b0, i_threshold};
    assign is_up       = {1'b0, i_sample} > high_limit;
    assign above_floor = i_sample > i_threshold;
    assign is_down     = above_floor && (low_sum < {1'b0, i_state.held});

    // Saturating jump counters.
    assign up_bump   = (i_state.up_cnt == '1) ? i_state.up_cnt : i_state.up_cnt + 1'b1;
    assign down_bump = (i_state.down_cnt == '1) ? i_state.down_cnt
                                                : i_state.down_cnt + 1'b1;

    // Ring sum with the oldest sample replaced by the new one.
    assign sum_new = i_state.sum - t_sum'(i_state.oldest) + t_sum'(i_sample);

    // Jump classification and counter handling.
    always_comb begin
        o_upd          = '0;
        o_upd.up_cnt   = i_state.up_cnt;
        o_upd.down_cnt = i_state.down_cnt;
        priority if (is_up) begin
            o_upd.enter  = up_bump > i_confirm;
            o_upd.up_cnt = o_upd.enter ? '0 : up_bump;
        end else if (is_down) begin
            o_upd.enter    = down_bump > i_confirm;
            o_upd.down_cnt = o_upd.enter ? '0 : down_bump;
        end else if (above_floor) begin
            o_upd.enter    = 1'b1;
            o_upd.down_cnt = '0;
        end else begin
            o_upd.enter    = 1'b1;
            o_upd.up_cnt   = '0;
            o_upd.down_cnt = '0;
        end
        o_upd.sum  = o_upd.enter ? sum_new : i_state.sum;
        o_upd.held = o_upd.enter ? t_sample'(sum_new >> POS_W) : i_state.held;
    end

endmodule

FILE: sv/sgma_state.sv
module sgma_state
    import sgma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_channel    i_rd_channel,
    output t_chan_state o_rd,
    input  logic        i_wr_en,
    input  t_channel    i_wr_channel,
    input  t_sample     i_sample,
    input  t_update     i_upd
);

    t_sample r_window [CHANNELS][WINDOW_LENGTH];
    t_pos    r_pos    [CHANNELS];
    t_sum    r_sum    [CHANNELS];
    t_sample r_held   [CHANNELS];
    t_count  r_up     [CHANNELS];
    t_count  r_down   [CHANNELS];

    // Read of the channel that the current item belongs to.
    always_comb begin
        o_rd.held     = r_held[i_rd_channel];
        o_rd.up_cnt   = r_up[i_rd_channel];
        o_rd.down_cnt = r_down[i_rd_channel];
        o_rd.sum      = r_sum[i_rd_channel];
        o_rd.oldest   = r_window[i_rd_channel][r_pos[i_rd_channel]];
    end

    // Per-channel state update; reset clears everything.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c]  <= '0;
                r_sum[c]  <= '0;
                r_held[c] <= '0;
                r_up[c]   <= '0;
                r_down[c] <= '0;
                for (int w = 0; w < WINDOW_LENGTH; w++) begin
                    r_window[c][w] <= '0;
                end
            end
        end else if (i_wr_en) begin
            r_up[i_wr_channel]   <= i_upd.up_cnt;
            r_down[i_wr_channel] <= i_upd.down_cnt;
            r_sum[i_wr_channel]  <= i_upd.sum;
            r_held[i_wr_channel] <= i_upd.held;
            if (i_upd.enter) begin
                r_window[i_wr_channel][r_pos[i_wr_channel]] <= i_sample;
                r_pos[i_wr_channel] <= (r_pos[i_wr_channel] == t_pos'(WINDOW_LENGTH - 1))
                                       ? '0 : r_pos[i_wr_channel] + 1'b1;
            end
        end
    end

    // A gated jump leaves the ring position alone.
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && !i_upd.enter) |=>
            r_pos[$past(i_wr_channel)] == $past(r_pos[i_wr_channel]))
        else $error("ring position moved on a gated jump");

    // The held value takes the update of the item.
    a_held_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_held[$past(i_wr_channel)] == $past(i_upd.held))
        else $error("held value not updated");

    // An accepted sample lands in the ring slot that was current.
    a_ring_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && i_upd.enter) |=>
            r_window[$past(i_wr_channel)][$past(r_pos[i_wr_channel])] == $past(i_sample))
        else $error("sample not written to ring");

endmodule

FILE: sv/spike_gated_moving_average.sv
// Moving average over the last 8 accepted samples of each of 4 ADC channels, with spike
// rejection: a sample more than jump_threshold above the channel's held value, or more
// than jump_threshold below it while above jump_threshold, only counts until its jump
// counter exceeds confirm_count; all other samples enter the average at once. The result
// item is the channel's held value after the sample. The block takes one item every
// cycle unless o_stall is high: an item is registered, then its channel state is read,
// updated and the result registered as it leaves the input register, so back-to-back
// items of the same channel see each other's updates. An output register lets a new
// item be taken while a result waits. Reset clears all channel state and loads threshold
// 64 and confirm count 3; users must write configuration only while idle (unenforced).
module spike_gated_moving_average
    import sgma_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic [CH_W-1:0]      i_channel,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SAMPLE_W-1:0]  o_filtered,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic        r_in_valid;
    t_sample     r_in_sample;
    t_channel    r_in_channel;
    logic        r_out_valid;
    t_sample     r_out_filtered;
    t_sample     r_threshold;
    t_count      r_confirm;
    logic        advance;
    logic        fire;
    t_chan_state chan_rd;
    t_update     upd;

    // The input stage moves on when the output register is free or being emptied.
    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_confirm   <= CONFIRM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_JUMP_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                REG_CONFIRM_COUNT:  r_confirm   <= i_cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_sample  <= i_sample;
            r_in_channel <= i_channel;
        end
    end

    sgma_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_channel (r_in_channel),
        .o_rd         (chan_rd),
        .i_wr_en      (fire),
        .i_wr_channel (r_in_channel),
        .i_sample     (r_in_sample),
        .i_upd        (upd)
    );

    sgma_gate u_gate (
        .i_sample    (r_in_sample),
        .i_state     (chan_rd),
        .i_threshold (r_threshold),
        .i_confirm   (r_confirm),
        .o_upd       (upd)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_filtered <= upd.held;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_filtered;

    // The input side only stalls with an item waiting in the input register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a pending item");

    // An item that leaves the input stage shows up as a result.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (o_valid && o_filtered == $past(upd.held)))
        else $error("processed item did not reach the output");

    // A waiting result blocks the input stage only while the output is stalled.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !i_stall) |-> !o_stall)
        else $error("input stalled while output was free");

endmodule
